@@ src/assert_macros.svh @@
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, cond)
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/bt_pkg.sv @@
// Types, codes and constants of the bencode tokenizer.
`timescale 1ns / 1ps
package bt_pkg;

  localparam int unsigned DEPTH_BITS_DEF = 8;
  localparam int unsigned LEN_BITS_DEF   = 32;
  localparam int unsigned MID_DEPTH      = 2;
  localparam int unsigned OUT_DEPTH      = 4;

  localparam logic [7:0] CH_I     = 8'h69;  // 'i'
  localparam logic [7:0] CH_E     = 8'h65;  // 'e'
  localparam logic [7:0] CH_L     = 8'h6c;  // 'l'
  localparam logic [7:0] CH_D     = 8'h64;  // 'd'
  localparam logic [7:0] CH_S     = 8'h73;  // 's'
  localparam logic [7:0] CH_COLON = 8'h3a;  // ':'
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [3:0] RADIX    = 4'd10;

  // Register byte addresses
  localparam logic [2:0] ADDR_MAX_STR_LEN = 3'd0;
  localparam logic [2:0] ADDR_MAX_DEPTH   = 3'd4;

  typedef enum logic [2:0] {
    KIND_INT_OPEN  = 3'd0,
    KIND_INT_BODY  = 3'd1,
    KIND_INT_CLOSE = 3'd2,
    KIND_STR_MARK  = 3'd3,
    KIND_STR_BODY  = 3'd4,
    KIND_LIST      = 3'd5,
    KIND_DICT      = 3'd6,
    KIND_CLOSE     = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_END = 2'd1,
    STAT_BAD = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    CLS_SPACE = 4'd0,
    CLS_DIGIT = 4'd1,
    CLS_I     = 4'd2,
    CLS_E     = 4'd3,
    CLS_L     = 4'd4,
    CLS_D     = 4'd5,
    CLS_COLON = 4'd6,
    CLS_MINUS = 4'd7,
    CLS_OTHER = 4'd8,
    CLS_END   = 4'd9
  } cls_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       at_end;
  } in_item_t;

  typedef struct packed {
    kind_e      token_kind;
    logic [7:0] token_byte;
    logic       token_first;
    logic       token_last;
    logic       token_empty;
    status_e    status;
  } result_t;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] data_byte;
  } cls_item_t;

  function automatic result_t make_token(kind_e kind, logic [7:0] b, logic first,
                                         logic last, logic empty);
    result_t r;
    r.token_kind  = kind;
    r.token_byte  = b;
    r.token_first = first;
    r.token_last  = last;
    r.token_empty = empty;
    r.status      = STAT_OK;
    return r;
  endfunction

  function automatic result_t make_status(status_e st);
    result_t r;
    r.token_kind  = KIND_INT_OPEN;
    r.token_byte  = 8'h00;
    r.token_first = 1'b0;
    r.token_last  = 1'b0;
    r.token_empty = 1'b0;
    r.status      = st;
    return r;
  endfunction

endpackage

@@ src/bt_fifo.sv @@
// Small register queue used between the tokenizer stages and at the output.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bt_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             wr_fire, rd_fire;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign wr_fire   = wr_en_i && !full_o;
  assign rd_fire   = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_fire) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_fire) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_fire && !rd_fire) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_fire && !wr_fire) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `ASSERT_ALWAYS(a_cnt_range, cnt_q <= CW'(DEPTH))
  `ASSERT_IMPL(a_ptr_meet, empty_o || full_o, wr_ptr_q == rd_ptr_q)
  `ASSERT_NEXT(a_cnt_track, wr_fire && !rd_fire, cnt_q == $past(cnt_q) + 1'b1)

endmodule

@@ src/bt_front.sv @@
// Front stage: accepts input transfers, classifies each byte and queues it.
`timescale 1ns / 1ps
module bt_front
  import bt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_item_t  item_i,
  output logic      full_o,
  output logic      valid_o,
  output cls_item_t cls_o,
  input  logic      pop_i
);

  cls_item_t cls_in;
  logic      mid_empty;
  logic      is_space, is_digit;
  logic [7:0] b;

  assign b        = item_i.data_byte;
  assign is_space = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

  always_comb begin
    cls_in.data_byte = b;
    if (item_i.at_end) begin
      cls_in.cls = CLS_END;
    end else if (is_space) begin
      cls_in.cls = CLS_SPACE;
    end else if (is_digit) begin
      cls_in.cls = CLS_DIGIT;
    end else begin
      case (b)
        CH_I:     cls_in.cls = CLS_I;
        CH_E:     cls_in.cls = CLS_E;
        CH_L:     cls_in.cls = CLS_L;
        CH_D:     cls_in.cls = CLS_D;
        CH_COLON: cls_in.cls = CLS_COLON;
        CH_MINUS: cls_in.cls = CLS_MINUS;
        default:  cls_in.cls = CLS_OTHER;
      endcase
    end
  end

  bt_fifo #(
    .WIDTH ($bits(cls_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push_i),
    .wr_data_i (cls_in),
    .full_o    (full_o),
    .rd_en_i   (pop_i),
    .rd_data_o (cls_o),
    .empty_o   (mid_empty)
  );

  assign valid_o = !mid_empty;

endmodule

@@ src/bt_back.sv @@
// Back stage: parser state machine, turns classified bytes into token results.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bt_back
  import bt_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = DEPTH_BITS_DEF,
  parameter int unsigned LEN_BITS   = LEN_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  cls_item_t   cls_i,
  output logic        pop_o,
  input  logic [31:0] max_str_len_i,
  input  logic [7:0]  max_depth_i,
  input  logic        out_full_i,
  output logic        out_wr_o,
  output result_t     out_data_o
);

  localparam logic [2:0] M_BETWEEN   = 3'd0;
  localparam logic [2:0] M_INT_FIRST = 3'd1;
  localparam logic [2:0] M_INT_BODY  = 3'd2;
  localparam logic [2:0] M_STR_LEN   = 3'd3;
  localparam logic [2:0] M_STR_BODY  = 3'd4;
  localparam logic [2:0] M_ERROR     = 3'd5;
  localparam logic [2:0] M_DONE      = 3'd6;

  localparam int unsigned NW = LEN_BITS + 4;
  localparam int unsigned CW = (NW > 32) ? NW : 32;
  localparam int unsigned DW = (DEPTH_BITS + 1 > 8) ? DEPTH_BITS + 1 : 8;

  logic [2:0]            mode_q, mode_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic [LEN_BITS-1:0]   rem_q, rem_d;
  logic [7:0]            held_byte_q, held_byte_d;
  logic                  held_valid_q, held_valid_d;
  logic                  held_first_q, held_first_d;
  logic                  pend_valid_q, pend_valid_d;
  result_t               pend_q, pend_d;

  logic                  go;
  logic [1:0]            n_res;
  result_t               r0, r1;
  logic [LEN_BITS-1:0]   len_base, rem_dec;
  logic [NW-1:0]         len_next;
  logic                  too_long, depth_full;
  logic [DW-1:0]         depth_inc;
  logic [7:0]            c;

  assign c  = cls_i.data_byte;
  assign go = valid_i && !pend_valid_q && !out_full_i;

  // Length accumulation: base * 10 + digit, as two shifted adds
  assign len_base = (mode_q == M_STR_LEN) ? rem_q : '0;
  assign len_next = (NW'(len_base) << 3) + (NW'(len_base) << 1) + NW'(c[3:0]);
  assign too_long = (len_next[NW-1:LEN_BITS] != '0) ||
                    (CW'(len_next) > CW'(max_str_len_i));

  assign depth_inc  = DW'(depth_q) + 1'b1;
  assign depth_full = (depth_q == '1) || (depth_inc > DW'(max_depth_i));
  assign rem_dec    = (rem_q != '0) ? rem_q - 1'b1 : '0;

  always_comb begin
    mode_d       = mode_q;
    depth_d      = depth_q;
    rem_d        = rem_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    held_first_d = held_first_q;
    n_res        = 2'd0;
    r0           = make_status(STAT_BAD);
    r1           = make_status(STAT_BAD);

    case (mode_q)
      M_BETWEEN: begin
        case (cls_i.cls)
          CLS_END: begin
            n_res = 2'd1;
            if (depth_q != '0) begin
              mode_d = M_ERROR;
            end else begin
              mode_d = M_DONE;
              r0     = make_status(STAT_END);
            end
          end
          CLS_SPACE: begin
            n_res = 2'd0;
          end
          CLS_I: begin
            n_res  = 2'd1;
            mode_d = M_INT_FIRST;
            r0     = make_token(KIND_INT_OPEN, c, 1'b1, 1'b1, 1'b0);
          end
          CLS_DIGIT: begin
            if (too_long) begin
              n_res  = 2'd1;
              mode_d = M_ERROR;
            end else begin
              rem_d  = len_next[LEN_BITS-1:0];
              mode_d = M_STR_LEN;
            end
          end
          CLS_L, CLS_D: begin
            n_res = 2'd1;
            if (depth_full) begin
              mode_d = M_ERROR;
            end else begin
              depth_d = depth_q + 1'b1;
              r0 = make_token((cls_i.cls == CLS_L) ? KIND_LIST : KIND_DICT, c,
                              1'b1, 1'b1, 1'b0);
            end
          end
          CLS_E: begin
            n_res = 2'd1;
            if (depth_q == '0) begin
              mode_d = M_ERROR;
            end else begin
              depth_d = depth_q - 1'b1;
              r0      = make_token(KIND_CLOSE, c, 1'b1, 1'b1, 1'b0);
            end
          end
          default: begin
            n_res  = 2'd1;
            mode_d = M_ERROR;
          end
        endcase
      end

      M_INT_FIRST, M_INT_BODY: begin
        if (cls_i.cls == CLS_DIGIT ||
            (cls_i.cls == CLS_MINUS && mode_q == M_INT_FIRST)) begin
          // previous held byte goes out now that it is known not to be last
          if (held_valid_q) begin
            n_res = 2'd1;
            r0 = make_token(KIND_INT_BODY, held_byte_q, held_first_q, 1'b0, 1'b0);
          end
          held_first_d = !held_valid_q;
          held_byte_d  = c;
          held_valid_d = 1'b1;
          mode_d       = M_INT_BODY;
        end else begin
          n_res = 2'd2;
          if (held_valid_q) begin
            r0 = make_token(KIND_INT_BODY, held_byte_q, held_first_q, 1'b1, 1'b0);
          end else begin
            r0 = make_token(KIND_INT_BODY, 8'h00, 1'b1, 1'b1, 1'b1);
          end
          held_valid_d = 1'b0;
          held_first_d = 1'b0;
          if (cls_i.cls == CLS_E) begin
            mode_d = M_BETWEEN;
            r1     = make_token(KIND_INT_CLOSE, c, 1'b1, 1'b1, 1'b0);
          end else begin
            mode_d = M_ERROR;
          end
        end
      end

      M_STR_LEN: begin
        n_res = 2'd1;
        case (cls_i.cls)
          CLS_DIGIT: begin
            if (too_long) begin
              mode_d = M_ERROR;
            end else begin
              n_res = 2'd0;
              rem_d = len_next[LEN_BITS-1:0];
            end
          end
          CLS_COLON: begin
            r0 = make_token(KIND_STR_MARK, CH_S, 1'b1, 1'b1, 1'b0);
            if (rem_q == '0) begin
              n_res  = 2'd2;
              mode_d = M_BETWEEN;
              r1     = make_token(KIND_STR_BODY, 8'h00, 1'b1, 1'b1, 1'b1);
            end else begin
              mode_d       = M_STR_BODY;
              held_first_d = 1'b1;
            end
          end
          default: begin
            mode_d = M_ERROR;
          end
        endcase
      end

      M_STR_BODY: begin
        n_res = 2'd1;
        if (cls_i.cls == CLS_END) begin
          mode_d = M_ERROR;
        end else begin
          held_first_d = 1'b0;
          rem_d        = rem_dec;
          if (rem_dec == '0) begin
            mode_d = M_BETWEEN;
          end
          r0 = make_token(KIND_STR_BODY, c, held_first_q, rem_dec == '0, 1'b0);
        end
      end

      M_DONE: begin
        n_res = 2'd1;
        r0    = make_status(STAT_END);
      end

      default: begin
        n_res  = 2'd1;
        mode_d = M_ERROR;
      end
    endcase

    if (mode_d == M_ERROR) begin
      held_valid_d = 1'b0;
    end
  end

  // Second result of an item waits here for a free output slot
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    if (pend_valid_q && !out_full_i) begin
      pend_valid_d = 1'b0;
    end
    if (go && n_res == 2'd2) begin
      pend_valid_d = 1'b1;
      pend_d       = r1;
    end
  end

  assign pop_o      = go;
  assign out_wr_o   = (pend_valid_q && !out_full_i) || (go && n_res != 2'd0);
  assign out_data_o = pend_valid_q ? pend_q : r0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= M_BETWEEN;
      depth_q      <= '0;
      rem_q        <= '0;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      held_first_q <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      if (go) begin
        mode_q       <= mode_d;
        depth_q      <= depth_d;
        rem_q        <= rem_d;
        held_byte_q  <= held_byte_d;
        held_valid_q <= held_valid_d;
        held_first_q <= held_first_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  `ASSERT_IMPL(a_no_pop_while_pend, pend_valid_q, !pop_o)
  `ASSERT_NEXT(a_error_sticky, mode_q == M_ERROR, mode_q == M_ERROR)
  `ASSERT_IMPL(a_held_in_int, held_valid_q, mode_q == M_INT_BODY)
  `ASSERT_IMPL(a_done_no_depth, mode_q == M_DONE, depth_q == '0)

endmodule

@@ src/bencode_tokenizer.sv @@
// Top level of the bencode tokenizer: register port, front and back stages.
//
// Usage: data bytes enter on item_i (push/full); an item with at_end set
// closes the stream. Token results leave on result_o (empty/pop), oldest
// first; each carries kind, byte, first/last/empty marks and a status.
// max_string_length (address 0) and max_nesting_depth (address 4) are
// written over the APB port between streams.
// Items pass through the input queue, the back stage and the output queue.
// Throughput: one item per cycle while the output queue has room; an item
// with two results (int close, empty string) holds the back stage until the
// second is written, as the output queue takes one result a cycle.
// Int body bytes come out one item late, as the newest one is held until
// the next byte shows whether it is the last.
// Reset clears the parser to "between tokens" with depth zero, empties
// both queues and sets both limits to all ones. When the receiver stalls,
// the output queue fills, then the two-entry input queue, then full rises.
`timescale 1ns / 1ps
module bencode_tokenizer
  import bt_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = DEPTH_BITS_DEF,
  parameter int unsigned LEN_BITS   = LEN_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  in_item_t    item_i,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output result_t     result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] max_str_len_q;
  logic [7:0]  max_depth_q;
  logic        cfg_wr;
  logic        mid_valid, mid_pop;
  cls_item_t   mid_item;
  logic        out_wr, out_full;
  result_t     out_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ADDR_MAX_DEPTH[2]) ? {24'h0, max_depth_q} : max_str_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_str_len_q <= '1;
      max_depth_q   <= '1;
    end else if (cfg_wr) begin
      if (paddr[2] == ADDR_MAX_STR_LEN[2]) begin
        max_str_len_q <= pwdata;
      end else begin
        max_depth_q <= pwdata[7:0];
      end
    end
  end

  bt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item_i),
    .full_o  (full),
    .valid_o (mid_valid),
    .cls_o   (mid_item),
    .pop_i   (mid_pop)
  );

  bt_back #(
    .DEPTH_BITS (DEPTH_BITS),
    .LEN_BITS   (LEN_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (mid_valid),
    .cls_i         (mid_item),
    .pop_o         (mid_pop),
    .max_str_len_i (max_str_len_q),
    .max_depth_i   (max_depth_q),
    .out_full_i    (out_full),
    .out_wr_o      (out_wr),
    .out_data_o    (out_data)
  );

  bt_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (out_wr),
    .wr_data_i (out_data),
    .full_o    (out_full),
    .rd_en_i   (pop),
    .rd_data_o (result_o),
    .empty_o   (empty)
  );

endmodule

@@ bench/bencode_tokenizer_checker.sv @@
// Scoreboard for the bencode tokenizer: predicts token results and compares them.
`timescale 1ns / 1ps
module bencode_tokenizer_checker
  import bt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  in_item_t    item_i,
  input  logic        empty,
  input  logic        pop,
  input  result_t     result_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  typedef enum logic [2:0] {
    PS_BETWEEN,
    PS_INT_FIRST,
    PS_INT_BODY,
    PS_STR_LEN,
    PS_STR_BODY,
    PS_BAD,
    PS_DONE
  } parse_state_e;

  parse_state_e                state;
  logic [DEPTH_BITS_DEF-1:0]   depth;
  logic [63:0]                 str_left;
  logic [7:0]                  held_byte;
  logic                        held_valid;
  logic                        held_first;
  logic [31:0]                 lim_str_len;
  logic [7:0]                  lim_depth;
  result_t                     token_q[$];

  function automatic void add_token(kind_e kind, logic [7:0] b, logic first, logic last,
                                    logic no_bytes);
    result_t r;
    r.token_kind  = kind;
    r.token_byte  = b;
    r.token_first = first;
    r.token_last  = last;
    r.token_empty = no_bytes;
    r.status      = STAT_OK;
    token_q.push_back(r);
  endfunction

  function automatic void add_status(status_e st);
    result_t r;
    r        = '0;
    r.status = st;
    token_q.push_back(r);
  endfunction

  function automatic void go_malformed();
    state      = PS_BAD;
    held_valid = 1'b0;
    add_status(STAT_BAD);
  endfunction

  // held int byte goes out as the last one, or an empty body if none was seen
  function automatic void flush_int_body();
    if (held_valid) begin
      add_token(KIND_INT_BODY, held_byte, held_first, 1'b1, 1'b0);
    end else begin
      add_token(KIND_INT_BODY, 8'h00, 1'b1, 1'b1, 1'b1);
    end
    held_valid = 1'b0;
    held_first = 1'b0;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void tokenize(in_item_t it);
    logic [7:0]  c;
    logic        fin;
    logic [63:0] len_cap;
    int unsigned depth_cap;
    logic        first_f;
    c         = it.data_byte;
    fin       = it.at_end;
    len_cap   = (64'd1 << LEN_BITS_DEF) - 64'd1;
    depth_cap = (1 << DEPTH_BITS_DEF) - 1;
    if (len_cap > {32'd0, lim_str_len}) len_cap = {32'd0, lim_str_len};
    if (depth_cap > lim_depth) depth_cap = lim_depth;
    case (state)
      PS_BETWEEN: begin
        if (fin) begin
          if (depth != 0) begin
            go_malformed();
          end else begin
            state = PS_DONE;
            add_status(STAT_END);
          end
        end else if (is_space(c)) begin
          // skipped
        end else if (c == CH_I) begin
          state = PS_INT_FIRST;
          add_token(KIND_INT_OPEN, c, 1'b1, 1'b1, 1'b0);
        end else if (is_digit(c)) begin
          str_left = c - CH_ZERO;
          if (str_left > len_cap) go_malformed();
          else state = PS_STR_LEN;
        end else if (c == CH_L || c == CH_D) begin
          if (int'(depth) + 1 > depth_cap) begin
            go_malformed();
          end else begin
            depth++;
            add_token(c == CH_L ? KIND_LIST : KIND_DICT, c, 1'b1, 1'b1, 1'b0);
          end
        end else if (c == CH_E) begin
          if (depth == 0) begin
            go_malformed();
          end else begin
            depth--;
            add_token(KIND_CLOSE, c, 1'b1, 1'b1, 1'b0);
          end
        end else begin
          go_malformed();
        end
      end
      PS_INT_FIRST, PS_INT_BODY: begin
        if (!fin && (is_digit(c) || (c == CH_MINUS && state == PS_INT_FIRST))) begin
          if (held_valid) add_token(KIND_INT_BODY, held_byte, held_first, 1'b0, 1'b0);
          held_first = !held_valid;
          held_byte  = c;
          held_valid = 1'b1;
          state      = PS_INT_BODY;
        end else begin
          flush_int_body();
          if (!fin && c == CH_E) begin
            state = PS_BETWEEN;
            add_token(KIND_INT_CLOSE, c, 1'b1, 1'b1, 1'b0);
          end else begin
            go_malformed();
          end
        end
      end
      PS_STR_LEN: begin
        if (fin) begin
          go_malformed();
        end else if (is_digit(c)) begin
          str_left = str_left * RADIX + (c - CH_ZERO);
          if (str_left > len_cap) go_malformed();
        end else if (c == CH_COLON) begin
          add_token(KIND_STR_MARK, CH_S, 1'b1, 1'b1, 1'b0);
          if (str_left == 0) begin
            state = PS_BETWEEN;
            add_token(KIND_STR_BODY, 8'h00, 1'b1, 1'b1, 1'b1);
          end else begin
            state      = PS_STR_BODY;
            held_first = 1'b1;
          end
        end else begin
          go_malformed();
        end
      end
      PS_STR_BODY: begin
        first_f = held_first;
        if (fin) begin
          go_malformed();
        end else begin
          held_first = 1'b0;
          if (str_left != 0) str_left--;
          if (str_left == 0) state = PS_BETWEEN;
          add_token(KIND_STR_BODY, c, first_f, str_left == 0, 1'b0);
        end
      end
      PS_DONE: add_status(STAT_END);
      default: go_malformed();
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t     want;
    logic [31:0] reg_val;
    if (!rst_ni) begin
      state            = PS_BETWEEN;
      depth            = '0;
      str_left         = '0;
      held_byte        = '0;
      held_valid       = 1'b0;
      held_first       = 1'b0;
      lim_str_len      = 32'hFFFF_FFFF;
      lim_depth        = 8'd255;
      mismatch_count_o = 0;
      token_q.delete();
      pending_o <= 0;
    end else begin
      // results are registered in the DUT after their item, so compare first
      if (pop && !empty) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d byte %0h status %0d",
                   $time, result_i.token_kind, result_i.token_byte, result_i.status);
          mismatch_count_o++;
        end else begin
          want = token_q.pop_front();
          check_field("token_kind", want.token_kind, result_i.token_kind);
          check_field("token_byte", want.token_byte, result_i.token_byte);
          check_field("token_first", want.token_first, result_i.token_first);
          check_field("token_last", want.token_last, result_i.token_last);
          check_field("token_empty", want.token_empty, result_i.token_empty);
          check_field("status", want.status, result_i.status);
        end
      end
      if (push && !full) tokenize(item_i);
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_MAX_STR_LEN) lim_str_len = pwdata;
          else if (paddr == ADDR_MAX_DEPTH) lim_depth = pwdata[7:0];
        end else begin
          reg_val = (paddr == ADDR_MAX_STR_LEN) ? lim_str_len : {24'd0, lim_depth};
          if (prdata !== reg_val) begin
            $display("%0t: register %0h read mismatch, expected %0h, got %0h",
                     $time, paddr, reg_val, prdata);
            mismatch_count_o++;
          end
        end
      end
      pending_o <= token_q.size();
    end
  end

endmodule

@@ bench/tb_bencode_tokenizer.sv @@
// Testbench top for the bencode tokenizer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_bencode_tokenizer;
  import bt_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 1000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned NUM_PHASES    = 5;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  in_item_t    in_item;
  logic        full;
  logic        empty;
  logic        pop;
  result_t     out_result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned idle_cycles;
  int unsigned stall_left;
  int unsigned stall_max;
  int unsigned gap_max;
  int unsigned burst_left;
  logic [31:0] str_lim;
  int unsigned depth_lim;
  in_item_t    stim_q[$];

  bencode_tokenizer dut (
    .clk_i,
    .rst_ni,
    .push,
    .item_i   (in_item),
    .full,
    .empty,
    .pop,
    .result_o (out_result),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  bencode_tokenizer_checker u_checker (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .item_i           (in_item),
    .empty,
    .pop,
    .result_i         (out_result),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: pops freely, now and then holds off for a random stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop        <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pop <= 1'b1;
      if (stall_max != 0 && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, stall_max);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL bencode_tokenizer");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void put_byte(logic [7:0] b);
    in_item_t it;
    it.data_byte = b;
    it.at_end    = 1'b0;
    stim_q.push_back(it);
  endfunction

  function automatic void put_end();
    in_item_t it;
    it.data_byte = 8'($urandom_range(0, 255));
    it.at_end    = 1'b1;
    stim_q.push_back(it);
  endfunction

  function automatic void put_decimal(logic [63:0] v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(CH_ZERO + 8'(v % RADIX));
      v = v / RADIX;
    end while (v != 0);
    foreach (digits[k]) put_byte(digits[k]);
  endfunction

  function automatic void put_space();
    int unsigned pick;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        pick = $urandom_range(0, 5);
        put_byte(pick == 5 ? CH_SPACE : CH_TAB + 8'(pick));
      end
    end
  endfunction

  // well-formed top-level values within the current limits, ending at depth zero
  function automatic void gen_document(int unsigned min_items);
    int unsigned open_n;
    int unsigned pick;
    int unsigned len;
    open_n = 0;
    while (stim_q.size() < min_items || open_n != 0) begin
      put_space();
      pick = $urandom_range(0, 9);
      if (open_n != 0 && (pick >= 8 || stim_q.size() >= min_items)) begin
        put_byte(CH_E);
        open_n--;
      end else if (pick >= 6 && open_n < depth_lim) begin
        put_byte($urandom_range(0, 1) ? CH_L : CH_D);
        open_n++;
      end else if (pick < 3) begin
        put_byte(CH_I);
        if ($urandom_range(0, 3) == 0) put_byte(CH_MINUS);
        repeat ($urandom_range(0, 6)) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        put_byte(CH_E);
      end else begin
        len = $urandom_range(0, str_lim < 12 ? str_lim : 12);
        if ($urandom_range(0, 7) == 0) put_byte(CH_ZERO);
        put_decimal(len);
        put_byte(CH_COLON);
        repeat (len) put_byte(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // one way to close the stream, well-formed or broken, then items that must stay sticky
  function automatic void gen_ending();
    int unsigned len;
    case ($urandom_range(0, 9))
      0: put_end();
      1: begin
        case ($urandom_range(0, 3))
          0: put_byte(CH_COLON);
          1: put_byte(CH_MINUS);
          2: put_byte(CH_S);
          default: put_byte(8'hFF);
        endcase
      end
      2: put_byte(CH_E);
      3: begin
        put_byte(CH_I);
        repeat ($urandom_range(0, 3)) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        put_end();
      end
      4: begin
        put_byte(CH_I);
        put_byte(CH_MINUS);
        put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        put_byte(CH_COLON);
      end
      5: begin
        put_decimal($urandom_range(0, str_lim));
        put_end();
      end
      6: begin
        len = $urandom_range(1, str_lim);
        put_decimal(len);
        put_byte(CH_COLON);
        repeat (len - 1) put_byte(8'($urandom_range(0, 255)));
        put_end();
      end
      7: begin
        put_decimal(64'(str_lim) + 64'd1);
        put_byte(CH_COLON);
      end
      8: repeat (depth_lim + 1) put_byte(CH_L);
      default: begin
        put_byte(CH_L);
        put_end();
      end
    endcase
    put_byte(8'($urandom_range(0, 255)));
    put_end();
    put_byte(8'($urandom_range(0, 255)));
  endfunction

  task automatic send_item(input in_item_t it);
    logic ok;
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push    <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk_i);
      ok = !full;
      @(posedge clk_i);
    end while (!ok);
  endtask

  task automatic send_all();
    while (stim_q.size() != 0) send_item(stim_q.pop_front());
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // leaves psel high; the caller drops it after the last transfer
  task automatic apb_transfer(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    logic rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic set_limits(input logic [31:0] len_max, input logic [7:0] nest_max);
    apb_transfer(1'b1, ADDR_MAX_STR_LEN, len_max);
    apb_transfer(1'b1, ADDR_MAX_DEPTH, {24'd0, nest_max});
    apb_transfer(1'b0, ADDR_MAX_STR_LEN, 32'd0);
    apb_transfer(1'b0, ADDR_MAX_DEPTH, 32'd0);
    psel    <= 1'b0;
    penable <= 1'b0;
    str_lim   = len_max;
    depth_lim = nest_max;
  endtask

  initial begin
    logic [31:0] len_cfg[NUM_PHASES];
    logic [7:0]  depth_cfg[NUM_PHASES];
    rst_ni     <= 1'b0;
    push       <= 1'b0;
    in_item    <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    stall_max  = $urandom_range(1, 16);
    gap_max    = $urandom_range(1, 8);
    burst_left = 0;
    str_lim    = 32'hFFFF_FFFF;
    depth_lim  = 255;
    len_cfg    = '{32'hFFFF_FFFF, 32'd0, 32'd3, 32'($urandom_range(1, 40)),
                   32'($urandom_range(1, 20))};
    depth_cfg  = '{8'd255, 8'd1, 8'd2, 8'($urandom_range(3, 10)), 8'($urandom_range(1, 6))};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset values read back
    apb_transfer(1'b0, ADDR_MAX_STR_LEN, 32'd0);
    apb_transfer(1'b0, ADDR_MAX_DEPTH, 32'd0);
    psel    <= 1'b0;
    penable <= 1'b0;

    // every token kind, empty int and string bodies, whitespace, byte extremes
    put_byte(CH_TAB);   put_byte(CH_L);     put_byte(CH_I);     put_byte(CH_MINUS);
    put_byte(CH_NINE);  put_byte(CH_ZERO);  put_byte(CH_E);     put_byte(CH_D);
    put_byte(CH_ZERO);  put_byte(CH_COLON); put_byte(CH_ZERO + 8'd2); put_byte(CH_COLON);
    put_byte(8'h00);    put_byte(8'hFF);    put_byte(CH_E);     put_byte(CH_CR);
    put_byte(CH_I);     put_byte(CH_E);     put_byte(CH_E);     put_byte(CH_SPACE);
    send_all();

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      set_limits(len_cfg[p], depth_cfg[p]);
      gap_max   = (p == 1) ? 0 : $urandom_range(0, 12);
      stall_max = (p == 1) ? 0 : $urandom_range(0, 16);
      gen_document(PHASE_ITEMS);
      if (p == NUM_PHASES - 1) gen_ending();
      send_all();
    end

    wait_drained();
    if (mismatches == 0 && pending == 0) begin
      $display("PASS bencode_tokenizer");
    end else begin
      $display("FAIL bencode_tokenizer");
    end
    $finish;
  end

endmodule
